### src/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, codes, item structures and helper functions for the
// complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int W      = 16;
    localparam int F      = 8;
    localparam int PW     = 2 * W;
    localparam int MW     = 2 * W + 1;
    localparam int QW     = W + 1;
    localparam int RW     = MW + QW;
    localparam int IN_DW  = ((4 * W + 7) / 8) * 8;
    localparam int OUT_DW = ((2 * W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_SUB = 3'd1,
        FN_MUL = 3'd2,
        FN_DIV = 3'd3,
        FN_LT  = 3'd4,
        FN_GT  = 3'd5,
        FN_EQ  = 3'd6,
        FN_NE  = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    typedef struct packed {
        logic          neg;
        logic [MW-1:0] mag;
    } t_smag;

    typedef struct packed {
        t_func func;
        logic  cmp;
        t_smag re;
        t_smag im;
        logic  den_zero;
    } t_side;

    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [RW-1:0] rem;
        logic [QW-1:0] q;
    } t_lane;

    function automatic t_smag to_smag(input logic signed [MW-1:0] v);
        t_smag s;
        s.neg = v[MW-1];
        s.mag = v[MW-1] ? (~v) + MW'(1) : v;
        return s;
    endfunction

    // {clamped flag, value}
    function automatic logic [W:0] saturate(input t_smag v);
        logic [MW-1:0] lim;
        logic [W-1:0]  val;
        logic          flag;
        lim  = v.neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
        flag = v.mag > lim;
        if (flag) begin
            val = v.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            val = v.neg ? (~v.mag[W-1:0]) + W'(1) : v.mag[W-1:0];
        end
        return {flag, val};
    endfunction

    function automatic t_lane div_step(input t_lane l, input logic [MW-1:0] den,
                                       input int sh);
        t_lane         o;
        logic [RW-1:0] trial;
        o     = l;
        trial = RW'(den) << sh;
        if (l.rem >= trial) begin
            o.rem = l.rem - trial;
            o.q   = {l.q[QW-2:0], 1'b1};
        end else begin
            o.q   = {l.q[QW-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

### src/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply, divide and compare on Q8.8 operands.
// ----------------------------------------------------------------------------
// Accepts one item per clock while the output is not stalled and delivers
// results in order through four front stages (operand register, products,
// sums, sign/magnitude), the divider's setup stage and one stage per quotient
// bit (17 in all), then the output register. The divider pipeline sets the
// latency. Back-pressure on the output stalls the whole pipeline.
module complex_arithmetic_unit import cau_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // a_real, a_imag, b_real, b_imag
    input  logic [IN_DW-1:0]  s_axis_tdata,
    // func
    input  logic [2:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // result_real, result_imag
    output logic [OUT_DW-1:0] m_axis_tdata,
    // compare_true, status[1:0]
    output logic [2:0]        m_axis_tuser
);

    logic          en;
    logic          f_vld, d_vld;
    t_side         f_side, d_side;
    t_smag         f_num_re, f_num_im;
    logic [MW-1:0] f_den;
    t_lane         d_re, d_im;

    assign s_axis_tready = en;

    cau_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (s_axis_tvalid),
        .i_func   (t_func'(s_axis_tuser)),
        .i_a      (s_axis_tdata[W-1:0]),
        .i_b      (s_axis_tdata[2*W-1:W]),
        .i_c      (s_axis_tdata[3*W-1:2*W]),
        .i_d      (s_axis_tdata[4*W-1:3*W]),
        .o_vld    (f_vld),
        .o_side   (f_side),
        .o_num_re (f_num_re),
        .o_num_im (f_num_im),
        .o_den    (f_den)
    );

    cau_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (f_vld),
        .i_side   (f_side),
        .i_num_re (f_num_re),
        .i_num_im (f_num_im),
        .i_den    (f_den),
        .o_vld    (d_vld),
        .o_side   (d_side),
        .o_re     (d_re),
        .o_im     (d_im)
    );

    cau_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (d_vld),
        .i_side   (d_side),
        .i_re     (d_re),
        .i_im     (d_im),
        .i_tready (m_axis_tready),
        .o_en     (en),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

endmodule

### src/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Operand register, product stage, sum stage and sign/magnitude stage.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  t_func               i_func,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    input  logic signed [W-1:0] i_c,
    input  logic signed [W-1:0] i_d,
    output logic                o_vld,
    output t_side               o_side,
    output t_smag               o_num_re,
    output t_smag               o_num_im,
    output logic [MW-1:0]       o_den
);

    logic                 r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    t_func                r_a_func, r_b_func, r_c_func;
    logic signed [W-1:0]  r_a_a, r_a_b, r_a_c, r_a_d;
    logic signed [PW-1:0] r_b_ac, r_b_bd, r_b_bc, r_b_ad, r_b_aa, r_b_bb, r_b_cc, r_b_dd;
    logic signed [W:0]    r_b_sre, r_b_sim, r_c_sre, r_c_sim;
    logic                 r_b_eq, r_c_eq;
    logic signed [MW-1:0] r_c_mre, r_c_mim, r_c_dre, r_c_dim, r_c_ma, r_c_mb, r_c_den;
    t_side                r_d_side, n_d_side;
    t_smag                r_d_num_re, r_d_num_im, n_mul_re, n_mul_im;
    logic [MW-1:0]        r_d_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_func <= i_func;
            r_a_a    <= i_a;
            r_a_b    <= i_b;
            r_a_c    <= i_c;
            r_a_d    <= i_d;

            r_b_func <= r_a_func;
            r_b_ac   <= r_a_a * r_a_c;
            r_b_bd   <= r_a_b * r_a_d;
            r_b_bc   <= r_a_b * r_a_c;
            r_b_ad   <= r_a_a * r_a_d;
            r_b_aa   <= r_a_a * r_a_a;
            r_b_bb   <= r_a_b * r_a_b;
            r_b_cc   <= r_a_c * r_a_c;
            r_b_dd   <= r_a_d * r_a_d;
            r_b_sre  <= (r_a_func == FN_SUB) ? (W+1)'(r_a_a) - (W+1)'(r_a_c)
                                             : (W+1)'(r_a_a) + (W+1)'(r_a_c);
            r_b_sim  <= (r_a_func == FN_SUB) ? (W+1)'(r_a_b) - (W+1)'(r_a_d)
                                             : (W+1)'(r_a_b) + (W+1)'(r_a_d);
            r_b_eq   <= (r_a_a == r_a_c) && (r_a_b == r_a_d);

            r_c_func <= r_b_func;
            r_c_sre  <= r_b_sre;
            r_c_sim  <= r_b_sim;
            r_c_eq   <= r_b_eq;
            r_c_mre  <= MW'(r_b_ac) - MW'(r_b_bd);
            r_c_mim  <= MW'(r_b_bc) + MW'(r_b_ad);
            r_c_dre  <= MW'(r_b_ac) + MW'(r_b_bd);
            r_c_dim  <= MW'(r_b_bc) - MW'(r_b_ad);
            r_c_ma   <= MW'(r_b_aa) + MW'(r_b_bb);
            r_c_mb   <= MW'(r_b_cc) + MW'(r_b_dd);
            r_c_den  <= MW'(r_b_cc) + MW'(r_b_dd);

            r_d_side   <= n_d_side;
            r_d_num_re <= to_smag(r_c_dre);
            r_d_num_im <= to_smag(r_c_dim);
            r_d_den    <= r_c_den;
        end
    end

    always_comb begin
        n_mul_re     = to_smag(r_c_mre);
        n_mul_im     = to_smag(r_c_mim);
        n_mul_re.mag = n_mul_re.mag >> F;
        n_mul_im.mag = n_mul_im.mag >> F;

        n_d_side.func     = r_c_func;
        n_d_side.den_zero = (r_c_den == '0);
        n_d_side.cmp      = 1'b0;
        n_d_side.re       = to_smag(MW'(r_c_sre));
        n_d_side.im       = to_smag(MW'(r_c_sim));
        case (r_c_func)
            FN_MUL: begin
                n_d_side.re = n_mul_re;
                n_d_side.im = n_mul_im;
            end
            FN_LT:   n_d_side.cmp = r_c_ma < r_c_mb;
            FN_GT:   n_d_side.cmp = r_c_ma > r_c_mb;
            FN_EQ:   n_d_side.cmp = r_c_eq;
            FN_NE:   n_d_side.cmp = !r_c_eq;
            default: n_d_side.cmp = 1'b0;
        endcase
    end

    assign o_vld    = r_d_vld;
    assign o_side   = r_d_side;
    assign o_num_re = r_d_num_re;
    assign o_num_im = r_d_num_im;
    assign o_den    = r_d_den;

endmodule

### src/cau_div.sv
// ----------------------------------------------------------------------------
// cau_div
// Restoring divider, one quotient bit per stage, two lanes sharing the
// divisor; side data travels alongside.
// ----------------------------------------------------------------------------
module cau_div import cau_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  t_side         i_side,
    input  t_smag         i_num_re,
    input  t_smag         i_num_im,
    input  logic [MW-1:0] i_den,
    output logic          o_vld,
    output t_side         o_side,
    output t_lane         o_re,
    output t_lane         o_im
);

    logic          r_vld  [0:QW];
    t_side         r_side [0:QW];
    logic [MW-1:0] r_den  [0:QW];
    t_lane         r_re   [0:QW];
    t_lane         r_im   [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k <= QW; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0]  <= i_side;
            r_den[0]   <= i_den;
            r_re[0].neg <= i_num_re.neg;
            r_re[0].ovf <= RW'(i_num_re.mag) >= (RW'(i_den) << (QW - F));
            r_re[0].rem <= RW'(i_num_re.mag) << F;
            r_re[0].q   <= '0;
            r_im[0].neg <= i_num_im.neg;
            r_im[0].ovf <= RW'(i_num_im.mag) >= (RW'(i_den) << (QW - F));
            r_im[0].rem <= RW'(i_num_im.mag) << F;
            r_im[0].q   <= '0;
            for (int k = 1; k <= QW; k++) begin
                r_side[k] <= r_side[k-1];
                r_den[k]  <= r_den[k-1];
                r_re[k]   <= div_step(r_re[k-1], r_den[k-1], QW - k);
                r_im[k]   <= div_step(r_im[k-1], r_den[k-1], QW - k);
            end
        end
    end

    assign o_vld  = r_vld[QW];
    assign o_side = r_side[QW];
    assign o_re   = r_re[QW];
    assign o_im   = r_im[QW];

endmodule

### src/cau_out.sv
// ----------------------------------------------------------------------------
// cau_out
// Result selection, saturation and the output register; drives the
// pipeline advance.
// ----------------------------------------------------------------------------
module cau_out import cau_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  t_side             i_side,
    input  t_lane             i_re,
    input  t_lane             i_im,
    input  logic              i_tready,
    output logic              o_en,
    output logic              o_tvalid,
    output logic [OUT_DW-1:0] o_tdata,
    output logic [2:0]        o_tuser
);

    logic          r_vld;
    logic [W-1:0]  r_re, r_im, n_re, n_im;
    logic          r_cmp, n_cmp;
    t_status       r_st, n_st;
    t_smag         q_re, q_im;
    logic [W:0]    s_re, s_im;

    assign o_en = !r_vld || i_tready;

    always_comb begin
        q_re.neg = i_re.neg;
        q_re.mag = i_re.ovf ? '1 : MW'(i_re.q);
        q_im.neg = i_im.neg;
        q_im.mag = i_im.ovf ? '1 : MW'(i_im.q);
        s_re     = saturate(i_side.re);
        s_im     = saturate(i_side.im);
        n_re     = '0;
        n_im     = '0;
        n_cmp    = 1'b0;
        n_st     = ST_OK;
        case (i_side.func) inside
            FN_ADD, FN_SUB, FN_MUL: begin
                n_re = s_re[W-1:0];
                n_im = s_im[W-1:0];
                n_st = (s_re[W] || s_im[W]) ? ST_SAT : ST_OK;
            end
            FN_DIV: begin
                s_re = saturate(q_re);
                s_im = saturate(q_im);
                if (i_side.den_zero) begin
                    n_st = ST_DIV0;
                end else begin
                    n_re = s_re[W-1:0];
                    n_im = s_im[W-1:0];
                    n_st = (s_re[W] || s_im[W]) ? ST_SAT : ST_OK;
                end
            end
            default: n_cmp = i_side.cmp;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_re  <= n_re;
            r_im  <= n_im;
            r_cmp <= n_cmp;
            r_st  <= n_st;
        end
    end

    assign o_tvalid = r_vld;
    assign o_tdata  = OUT_DW'({r_im, r_re});
    assign o_tuser  = {r_st, r_cmp};

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_cmp) |-> (r_st == ST_OK && r_re == '0 && r_im == '0))
        else $error("comparison item carries arithmetic data");

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_st == ST_DIV0) |-> (r_re == '0 && r_im == '0 && !r_cmp))
        else $error("divide-by-zero item not zeroed");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_st == ST_SAT) |->
            (r_re == {1'b1, {(W-1){1'b0}}} || r_re == {1'b0, {(W-1){1'b1}}} ||
             r_im == {1'b1, {(W-1){1'b0}}} || r_im == {1'b0, {(W-1){1'b1}}}))
        else $error("saturated item holds no limit value");

endmodule
